// ===== src/assert_macros.svh =====
// assertion helpers used by the mrpn_checker file
// each macro expects clk and rst to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define CHK_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mrpn_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpn_pkg
// shared constants, item types and helpers of the mean removal normalizer
// ----------------------------------------------------------------------------
package mrpn_pkg;

  localparam int FRAME_DEPTH  = 64;
  localparam int SAMPLE_WIDTH = 16;

  localparam int ADDR_W  = $clog2(FRAME_DEPTH);
  localparam int CNT_W   = $clog2(FRAME_DEPTH + 1);
  localparam int SUM_W   = SAMPLE_WIDTH + $clog2(FRAME_DEPTH);
  localparam int DEV_W   = SAMPLE_WIDTH + 1;
  localparam int OUT_W   = 18;
  localparam int Q_FRAC  = 16;
  localparam int MAG_W   = Q_FRAC + 1;
  localparam int Q16_ONE = 65536;

  // divider sizes: numerator covers |sum| and |x - mean| * 2^16
  localparam int NUM_SCALED_W = DEV_W + Q_FRAC;
  localparam int DIV_NW = (SUM_W > NUM_SCALED_W) ? SUM_W : NUM_SCALED_W;
  localparam int DIV_DW = (CNT_W > DEV_W) ? CNT_W : DEV_W;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // pass-through arithmetic width
  localparam int PT_W = SAMPLE_WIDTH + Q_FRAC + 2;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_out;
    logic                    was_normalized;
    logic                    last_out;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  // x * 2^16 / 2^(SAMPLE_WIDTH-1), truncated toward zero, clamped to +-1.0
  function automatic logic signed [OUT_W-1:0] pass_scale(logic signed [SAMPLE_WIDTH-1:0] v);
    logic signed [PT_W-1:0] t;
    t = PT_W'(v);
    t = t <<< Q_FRAC;
    if (v < 0) begin
      t = t + PT_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    end
    t = t >>> (SAMPLE_WIDTH - 1);
    if (t > PT_W'(Q16_ONE)) begin
      t = PT_W'(Q16_ONE);
    end else if (t < -PT_W'(Q16_ONE)) begin
      t = -PT_W'(Q16_ONE);
    end
    return t[OUT_W-1:0];
  endfunction

endpackage

// ===== src/mrpn_ram.sv =====
// ----------------------------------------------------------------------------
// mrpn_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mrpn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mrpn_div.sv =====
// ----------------------------------------------------------------------------
// mrpn_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mrpn_div (
  input  logic                clk,
  input  logic                rst,
  input  mrpn_pkg::div_req_t  req,
  output mrpn_pkg::div_rsp_t  rsp
);
  import mrpn_pkg::*;

  logic [DIV_NW-1:0] work;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [DIV_CW-1:0] cnt;
  logic              done;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              fits;

  assign rem_sh  = {rem, work[DIV_NW-1]};
  assign fits    = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        work <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (cnt != '0) begin
        // quotient bits shift in from the bottom as dividend bits leave the top
        rem  <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        work <= {work[DIV_NW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = work;

endmodule

// ===== src/mean_removal_peak_normalizer.sv =====
// ----------------------------------------------------------------------------
// mean_removal_peak_normalizer
// frame buffer with dc removal and peak normalization to signed q1.16
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | item
//  ---------+-----------+------------------------+------------------------------
//  src      | in        | src_valid / src_ready  | sample_in, frame_end
//  res      | out       | res_valid / res_ready  | sample_out, was_normalized,
//           |           |                        | last_out
//  cfg      | in        | cfg_write              | cfg_data = normalize_enable
//
//  loading takes one item per cycle; src_ready is low while a frame drains
//  at flush the divider computes the mean from |sum| and the item count
//  each result then passes the read, calc and emit states; a normalized
//  result also waits in div_wait for its division by the peak deviation
//  reset is synchronous; the sample buffer needs no clearing pass, only
//  entries written in the current frame are read
//  a stalled res side holds one result while the next one is computed
//
module mean_removal_peak_normalizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                src_valid,
  output logic                src_ready,
  input  mrpn_pkg::in_item_t  src_item,
  output logic                res_valid,
  input  logic                res_ready,
  output mrpn_pkg::out_item_t res_item
);
  import mrpn_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_LOAD      = 3'd0;  // taking samples
  localparam logic [2:0] ST_MEAN      = 3'd1;  // launch sum / count
  localparam logic [2:0] ST_MEAN_WAIT = 3'd2;
  localparam logic [2:0] ST_DEV       = 3'd3;  // peak deviation and mode
  localparam logic [2:0] ST_READ      = 3'd4;  // buffer read issued
  localparam logic [2:0] ST_CALC      = 3'd5;  // read data back
  localparam logic [2:0] ST_DIV_WAIT  = 3'd6;
  localparam logic [2:0] ST_EMIT      = 3'd7;  // hand result to output reg

  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(FRAME_DEPTH - 1);

  logic [2:0] state;

  // frame statistics
  logic        [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0]        sum;
  logic signed [SAMPLE_WIDTH-1:0] smax;
  logic signed [SAMPLE_WIDTH-1:0] smin;
  logic                           enable;

  // flush working registers
  logic signed [SAMPLE_WIDTH-1:0] mean;
  logic        [DEV_W-1:0]        dev;
  logic                           norm;
  logic        [CNT_W-1:0]        k;
  logic                           neg;
  logic signed [OUT_W-1:0]        result;

  // buffer ram
  logic                    ram_we;
  logic                    ram_re;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept;
  logic flush;
  logic last_k;

  // combinational helpers
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic        [SUM_W-1:0]        sum_mag;
  logic signed [SAMPLE_WIDTH:0]   q_s;
  logic signed [SAMPLE_WIDTH:0]   mean_full;
  logic signed [SAMPLE_WIDTH:0]   dmax;
  logic signed [SAMPLE_WIDTH:0]   dmin;
  logic        [DEV_W-1:0]        dev_calc;
  logic signed [SAMPLE_WIDTH:0]   diff;
  logic        [DEV_W-1:0]        diff_mag;
  logic        [MAG_W-1:0]        q_mag;
  logic signed [OUT_W-1:0]        q_signed;

  assign src_ready = (state == ST_LOAD);
  assign accept    = src_valid && src_ready;
  assign x         = src_item.sample_in;
  // flush on marked end or when this item fills the last slot
  assign flush     = src_item.frame_end || (count == LAST_SLOT);
  assign last_k    = (k + 1'b1) == count;

  assign ram_we = accept;
  assign ram_re = (state == ST_READ);

  mrpn_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (FRAME_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (x),
    .re    (ram_re),
    .raddr (k[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  mrpn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    // magnitude of the running sum for the mean division
    sum_mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    // signed mean from the unsigned quotient, truncated toward zero
    q_s       = $signed({1'b0, div_rsp.quo[SAMPLE_WIDTH-1:0]});
    mean_full = neg ? -q_s : q_s;
    // mean lies between min and max, so both distances are non-negative
    dmax      = (SAMPLE_WIDTH + 1)'(smax) - (SAMPLE_WIDTH + 1)'(mean);
    dmin      = (SAMPLE_WIDTH + 1)'(mean) - (SAMPLE_WIDTH + 1)'(smin);
    dev_calc  = (dmax > dmin) ? DEV_W'(dmax) : DEV_W'(dmin);
    // deviation of the read-back sample
    diff      = (SAMPLE_WIDTH + 1)'($signed(ram_rdata)) - (SAMPLE_WIDTH + 1)'(mean);
    diff_mag  = diff[SAMPLE_WIDTH] ? DEV_W'(-diff) : DEV_W'(diff);
    // clamp the scaled quotient to one and restore the sign
    q_mag     = (div_rsp.quo > DIV_NW'(Q16_ONE)) ? MAG_W'(Q16_ONE)
                                                 : div_rsp.quo[MAG_W-1:0];
    q_signed  = neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = DIV_NW'(sum_mag);
    div_req.den   = DIV_DW'(count);
    unique case (state)
      ST_MEAN: begin
        div_req.start = 1'b1;
      end
      ST_CALC: begin
        div_req.start = norm;
        div_req.num   = DIV_NW'({diff_mag, {Q_FRAC{1'b0}}});
        div_req.den   = DIV_DW'(dev);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_write) begin
      enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      sum       <= '0;
      smax      <= '0;
      smin      <= '0;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      // the emit state refills the output register itself
      if (res_valid && res_ready && (state != ST_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            count <= count + 1'b1;
            sum   <= sum + SUM_W'(x);
            if (x > smax) begin
              smax <= x;
            end
            if (x < smin) begin
              smin <= x;
            end
            if (flush) begin
              state <= ST_MEAN;
            end
          end
        end
        ST_MEAN: begin
          neg   <= sum[SUM_W-1];
          state <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean  <= mean_full[SAMPLE_WIDTH-1:0];
            state <= ST_DEV;
          end
        end
        ST_DEV: begin
          dev   <= dev_calc;
          norm  <= enable && (smax != mean) && (dev_calc != '0);
          k     <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (norm) begin
            neg   <= diff[SAMPLE_WIDTH];
            state <= ST_DIV_WAIT;
          end else begin
            result <= pass_scale($signed(ram_rdata));
            state  <= ST_EMIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            result <= q_signed;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // output register free or emptying this cycle
          if (!res_valid || res_ready) begin
            res_valid               <= 1'b1;
            res_item.sample_out     <= result;
            res_item.was_normalized <= norm;
            res_item.last_out       <= last_k;
            if (last_k) begin
              count <= '0;
              sum   <= '0;
              smax  <= '0;
              smin  <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= ST_READ;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== src/mrpn_checker.sv =====
// ----------------------------------------------------------------------------
// mrpn_checker
// port-level checks of the normalizer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrpn_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_ready,
  input logic                res_valid,
  input logic                res_ready,
  input mrpn_pkg::out_item_t res_item
);
  import mrpn_pkg::*;

  `CHK_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "res item dropped while stalled")
  `CHK_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_item),
            "res item changed while stalled")
  `CHK_IMPLIES(a_no_load_mid_frame, res_valid && !res_item.last_out, !src_ready,
               "src taken while a frame drains")
  `CHK_NEXT(a_mode_per_frame, res_valid && res_ready && !res_item.last_out,
            !res_valid || (res_item.was_normalized == $past(res_item.was_normalized)),
            "normalized flag changed inside a frame")

endmodule

bind mean_removal_peak_normalizer mrpn_checker u_mrpn_checker (
  .clk       (clk),
  .rst       (rst),
  .src_ready (src_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);

// ===== tb/norm_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// norm_frame_checker
// watches the sample and result channels of the normalizer, predicts every
// result from the accepted samples and compares them in order
// ----------------------------------------------------------------------------
module norm_frame_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                src_valid,
  input  logic                src_ready,
  input  mrpn_pkg::in_item_t  src_item,
  input  logic                res_valid,
  input  logic                res_ready,
  input  mrpn_pkg::out_item_t res_item,
  output int                  mismatches,
  output int                  outstanding
);
  import mrpn_pkg::*;

  localparam int MAX_PRINTS = 40;

  logic signed [SAMPLE_WIDTH-1:0] frame_buf [FRAME_DEPTH];
  int        fill;
  longint    acc_sum;
  longint    peak_hi;
  longint    peak_lo;
  logic      norm_en;
  int        results_seen;
  out_item_t norm_results_q [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t: result %0d %s: got %0d expected %0d",
               $time, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // mean, deviation and one expected result per buffered sample
  task automatic flush_frame();
    longint    mean;
    longint    dhi;
    longint    dlo;
    longint    dev;
    longint    q;
    longint    full_scale;
    logic      scale;
    out_item_t e;
    mean = acc_sum / longint'(fill);
    dhi = peak_hi - mean;
    if (dhi < 0) dhi = -dhi;
    dlo = peak_lo - mean;
    if (dlo < 0) dlo = -dlo;
    dev = (dhi > dlo) ? dhi : dlo;
    scale = norm_en && (peak_hi != mean) && (dev > 0);
    full_scale = longint'(1) << (SAMPLE_WIDTH - 1);
    for (int k = 0; k < fill; k++) begin
      if (scale) begin
        q = ((longint'(frame_buf[k]) - mean) * Q16_ONE) / dev;
      end else begin
        q = (longint'(frame_buf[k]) * Q16_ONE) / full_scale;
      end
      if (q > Q16_ONE) q = Q16_ONE;
      if (q < -Q16_ONE) q = -Q16_ONE;
      e.sample_out     = q[OUT_W-1:0];
      e.was_normalized = scale;
      e.last_out       = (k == fill - 1);
      norm_results_q.push_back(e);
    end
    fill    = 0;
    acc_sum = 0;
    peak_hi = 0;
    peak_lo = 0;
  endtask

  task automatic take_sample(input in_item_t it);
    longint x;
    x = longint'(it.sample_in);
    frame_buf[fill] = it.sample_in;
    fill++;
    acc_sum += x;
    if (x > peak_hi) peak_hi = x;
    if (x < peak_lo) peak_lo = x;
    if (it.frame_end || fill == FRAME_DEPTH) begin
      flush_frame();
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (norm_results_q.size() == 0) begin
      report_mismatch("with nothing pending, sample_out", longint'(got.sample_out), 0);
    end else begin
      want = norm_results_q.pop_front();
      if (got.sample_out !== want.sample_out) begin
        report_mismatch("sample_out", longint'(got.sample_out), longint'(want.sample_out));
      end
      if (got.was_normalized !== want.was_normalized) begin
        report_mismatch("was_normalized", got.was_normalized, want.was_normalized);
      end
      if (got.last_out !== want.last_out) begin
        report_mismatch("last_out", got.last_out, want.last_out);
      end
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill         = 0;
      acc_sum      = 0;
      peak_hi      = 0;
      peak_lo      = 0;
      norm_en      = 1'b1;
      mismatches   = 0;
      results_seen = 0;
      norm_results_q.delete();
    end else begin
      if (cfg_write) norm_en = cfg_data;
      if (res_valid && res_ready) check_result(res_item);
      if (src_valid && src_ready) take_sample(src_item);
    end
    outstanding = norm_results_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the mean removal peak normalizer: directed frames,
// then random frames under both enable settings with random idling on both
// channels, one long result stall and a quiet closing stretch
// ----------------------------------------------------------------------------
module tb;
  import mrpn_pkg::*;

  // wait after the last result before touching the config or ending
  localparam int SETTLE_CYCLES = 60;
  // tail after everything drained, well past one mean plus one division
  localparam int DRAIN_CYCLES  = 200;
  // receiver hold-off, long enough for a whole frame to load and block
  localparam int LONG_HOLD     = 400;
  // hard stop, far beyond the slowest correct run
  localparam longint LIMIT_NS  = 5_000_000;

  // sample shapes used to build random frames
  typedef enum int {
    WIDE,      // uniform over the whole range, every bit toggles
    FLAT,      // one non-negative constant, max equals mean
    NEAR_DC,   // small ripple on a large offset
    NEGATIVE,  // all below zero, max stays at its zero start
    EXTREMES,  // only full scale, zero and minus one lsb
    DRIFT      // wider ripple around an offset
  } wave_kind_t;

  logic      clk;
  logic      rst;
  logic      cfg_write;
  logic      cfg_data;
  logic      src_valid;
  logic      src_ready;
  in_item_t  src_item;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;

  int   mismatches;
  int   outstanding;
  logic calm;       // no idling on either side
  logic hold_req;   // asks the receiver for its one long hold-off
  logic hold_done;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  mean_removal_peak_normalizer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  norm_frame_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .src_item    (src_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // offer one item, optionally after an idle burst; called at a rising edge
  // and returns at the edge that accepted the item
  task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic fe);
    in_item_t it;
    it.sample_in = s;
    it.frame_end = fe;
    if (!calm && $urandom_range(0, 5) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    do @(posedge clk); while (!src_ready);
  endtask

  // drop valid and wait until every predicted result has come back
  // the extra edge lets the checker see the item that was just accepted
  task automatic settle();
    src_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_enable(input logic v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input wave_kind_t kind,
                                                                 input int base);
    int v;
    case (kind)
      WIDE:     v = int'($urandom_range(0, 65535)) - 32768;
      FLAT:     v = base;
      NEAR_DC:  v = base + int'($urandom_range(0, 512)) - 256;
      NEGATIVE: v = -int'($urandom_range(1, 32768));
      EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default:  v = base + int'($urandom_range(0, 8191)) - 4096;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // random frames until about n_items went in; mostly short frames, some
  // that fill the buffer, where frame_end on the last sample is random
  task automatic run_frames(input int n_items, input logic full_first);
    int         sent;
    int         len;
    int         base;
    logic       fe;
    wave_kind_t kind;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0:       len = FRAME_DEPTH;
        1, 2:    len = $urandom_range(1, 3);
        default: len = $urandom_range(4, 16);
      endcase
      if (sent == 0 && full_first) len = FRAME_DEPTH;
      kind = wave_kind_t'($urandom_range(0, 5));
      if (kind == FLAT) begin
        base = $urandom_range(0, 32767);
      end else begin
        base = int'($urandom_range(0, 40000)) - 20000;
      end
      for (int k = 0; k < len; k++) begin
        if (k < len - 1) begin
          fe = 1'b0;
        end else if (len == FRAME_DEPTH) begin
          fe = 1'($urandom_range(0, 1));
        end else begin
          fe = 1'b1;
        end
        push_sample(pick_sample(kind, base), fe);
      end
      sent += len;
    end
    settle();
  endtask

  // receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    res_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
        res_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    src_valid = 1'b0;
    src_item  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames, normalization on from reset
    // single full-scale positive: max equals mean, passed through
    push_sample(16'sh7FFF, 1'b1);
    // single most negative: max stays zero, deviation is full scale
    push_sample(-16'sd32768, 1'b1);
    // both extremes, mean truncates toward zero
    push_sample(16'sh7FFF, 1'b0);
    push_sample(-16'sd32768, 1'b1);
    // all zero: max equals mean at zero
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b1);
    // positive constant: max equals mean
    push_sample(16'sd100, 1'b0);
    push_sample(16'sd100, 1'b1);
    // small mixed frame of both signs whose mean divides exactly to one
    push_sample(-16'sd5, 1'b0);
    push_sample(16'sd3, 1'b0);
    push_sample(16'sd7, 1'b0);
    push_sample(-16'sd1, 1'b1);
    // mean truncates to zero, deviation one
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd0, 1'b1);
    // negative constant: max stays at zero, so scaling applies
    push_sample(-16'sd300, 1'b0);
    push_sample(-16'sd300, 1'b1);
    // extremes plus one lsb
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sd1, 1'b1);
    settle();

    // pass-through setting
    write_enable(1'b0);
    run_frames(60, 1'b0);

    // normalizing, opening with a full buffer while the receiver holds off
    write_enable(1'b1);
    hold_req = 1'b1;
    run_frames(170, 1'b1);

    write_enable(1'b0);
    run_frames(20, 1'b0);

    // closing stretch without idling
    write_enable(1'b1);
    calm = 1'b1;
    run_frames(40, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
